// ----- sv/rgbhsv_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsv_pkg: shared types and constants
// Pixel and result request types, divider stage record and pipeline sizes.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

	localparam int CH_W       = 8;                       // channel byte width
	localparam int HUE_W      = 16;                      // hue fraction width
	localparam int HDIV_W     = 11;                      // 6*d fits below 2048
	localparam int HREM_W     = HDIV_W + 1;              // shifted remainder
	localparam int SDIVD_W    = 2 * CH_W;                // 255*d dividend
	localparam int HUE_STEP   = 2;                       // hue bits per stage
	localparam int DIV_STAGES = HUE_W / HUE_STEP;        // divider depth
	localparam int FRONT_STG  = 2;                       // sort and numerator
	localparam int LATENCY    = FRONT_STG + DIV_STAGES;  // start to done

	// Input request: one RGB pixel
	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pix_t;

	// Result request: hue, saturation, value
	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [CH_W-1:0]  saturation;
		logic [CH_W-1:0]  brightness;
	} hsv_t;

	// Divider stage record: partial remainders, divisors and quotients
	typedef struct packed {
		logic [HDIV_W-1:0] hrem;    // hue remainder, below hdiv
		logic [HDIV_W-1:0] hdiv;    // 6*d, all ones for gray
		logic [CH_W-1:0]   srem;    // saturation remainder, below sdiv
		logic [CH_W-1:0]   sdiv;    // max channel, all ones for black
		logic [CH_W-1:0]   sbits;   // dividend bits still to bring down
		logic [HUE_W-1:0]  hq;      // hue quotient so far
		logic [CH_W-1:0]   sq;      // saturation quotient so far
		logic [CH_W-1:0]   bright;  // max channel
	} div_stage_t;

endpackage
`default_nettype wire

// ----- sv/rgbhsv_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsv_front: channel sort and divider setup
// Stage 1 finds max, min and hue sector; stage 2 forms chroma, hue numerator,
// both divisors and the saturation dividend 255*chroma.
// ----------------------------------------------------------------------------
module rgbhsv_front
	import rgbhsv_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_vld,
	input  wire pix_t       pixel,
	output      logic       out_vld,
	output      div_stage_t out_req
);

	typedef enum logic [1:0] {
		SEC_RED_UP,    // red max, green >= blue: offset 0
		SEC_RED_WRAP,  // red max, green < blue: offset 6
		SEC_GREEN,     // offset 2
		SEC_BLUE       // offset 4
	} sector_t;

	logic            vld_s1;
	logic [CH_W-1:0] mx_s1, mn_s1, x_s1, y_s1;
	sector_t         sec_s1;

	logic [CH_W-1:0] mx_c, mn_c, x_c, y_c;
	sector_t         sec_c;

	// Pick max channel in red, green, blue order, and the min channel
	always_comb begin
		if (pixel.red >= pixel.green && pixel.red >= pixel.blue) begin
			mx_c  = pixel.red;
			x_c   = pixel.green;
			y_c   = pixel.blue;
			sec_c = (pixel.green < pixel.blue) ? SEC_RED_WRAP : SEC_RED_UP;
		end else if (pixel.green >= pixel.blue) begin
			mx_c  = pixel.green;
			x_c   = pixel.blue;
			y_c   = pixel.red;
			sec_c = SEC_GREEN;
		end else begin
			mx_c  = pixel.blue;
			x_c   = pixel.red;
			y_c   = pixel.green;
			sec_c = SEC_BLUE;
		end
		mn_c = pixel.red;
		if (pixel.green < mn_c) mn_c = pixel.green;
		if (pixel.blue < mn_c) mn_c = pixel.blue;
	end

	// Stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		mx_s1  <= mx_c;
		mn_s1  <= mn_c;
		x_s1   <= x_c;
		y_s1   <= y_c;
		sec_s1 <= sec_c;
	end

	logic [CH_W-1:0]    d_c;
	logic [HDIV_W-1:0]  d6_c, offd_c, num_c;
	logic [SDIVD_W-1:0] sdvd_c;

	// Chroma, sector offset times chroma, and hue numerator
	always_comb begin
		d_c  = mx_s1 - mn_s1;
		d6_c = {1'b0, d_c, 2'b00} + {2'b00, d_c, 1'b0};
		case (sec_s1)
			SEC_RED_UP:   offd_c = '0;
			SEC_RED_WRAP: offd_c = d6_c;
			SEC_GREEN:    offd_c = {2'b00, d_c, 1'b0};
			SEC_BLUE:     offd_c = {1'b0, d_c, 2'b00};
			default:      offd_c = '0;
		endcase
		// numerator lies in [0, 6d), so modular arithmetic is exact
		num_c  = offd_c + {3'b000, x_s1} - {3'b000, y_s1};
		sdvd_c = {d_c, {CH_W{1'b0}}} - {{CH_W{1'b0}}, d_c};
	end

	// Stage 2 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		// gray: numerator is zero, an all-ones divisor keeps hue at zero
		out_req.hrem   <= num_c;
		out_req.hdiv   <= (d_c == '0) ? {HDIV_W{1'b1}} : d6_c;
		out_req.srem   <= sdvd_c[SDIVD_W-1:CH_W];
		// black: dividend is zero, an all-ones divisor keeps saturation at zero
		out_req.sdiv   <= (mx_s1 == '0) ? {CH_W{1'b1}} : mx_s1;
		out_req.sbits  <= sdvd_c[CH_W-1:0];
		out_req.hq     <= '0;
		out_req.sq     <= '0;
		out_req.bright <= mx_s1;
	end

endmodule
`default_nettype wire

// ----- sv/rgbhsv_divider.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsv_divider: pipelined restoring divider pair
// Each stage retires two hue quotient bits and one saturation quotient bit.
// ----------------------------------------------------------------------------
module rgbhsv_divider
	import rgbhsv_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_vld,
	input  wire div_stage_t in_req,
	output      logic       out_vld,
	output      hsv_t       out_res
);

	logic       vld_sn [1:DIV_STAGES];
	div_stage_t stg_sn [1:DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic       cur_vld;
		div_stage_t cur;
		div_stage_t nxt;

		// Feed the first stage from the divider input, the rest from the stage before
		if (k == 0) begin : g_head
			assign cur_vld = in_vld;
			assign cur     = in_req;
		end else begin : g_body
			assign cur_vld = vld_sn[k];
			assign cur     = stg_sn[k];
		end

		// Advance both long divisions by one stage
		always_comb begin
			logic [HREM_W-1:0] hr;
			logic [CH_W:0]     sr;
			nxt = cur;
			for (int i = 0; i < HUE_STEP; i++) begin
				hr = {nxt.hrem, 1'b0};
				if (hr >= {1'b0, nxt.hdiv}) begin
					hr = hr - {1'b0, nxt.hdiv};
					nxt.hq = {nxt.hq[HUE_W-2:0], 1'b1};
				end else begin
					nxt.hq = {nxt.hq[HUE_W-2:0], 1'b0};
				end
				nxt.hrem = hr[HDIV_W-1:0];
			end
			sr = {nxt.srem, nxt.sbits[CH_W-1]};
			if (sr >= {1'b0, nxt.sdiv}) begin
				sr = sr - {1'b0, nxt.sdiv};
				nxt.sq = {nxt.sq[CH_W-2:0], 1'b1};
			end else begin
				nxt.sq = {nxt.sq[CH_W-2:0], 1'b0};
			end
			nxt.srem  = sr[CH_W-1:0];
			nxt.sbits = {nxt.sbits[CH_W-2:0], 1'b0};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[k+1] <= 1'b0;
			end else begin
				vld_sn[k+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			stg_sn[k+1] <= nxt;
		end
	end

	// Present the finished quotients
	assign out_vld            = vld_sn[DIV_STAGES];
	assign out_res.hue        = stg_sn[DIV_STAGES].hq;
	assign out_res.saturation = stg_sn[DIV_STAGES].sq;
	assign out_res.brightness = stg_sn[DIV_STAGES].bright;

endmodule
`default_nettype wire

// ----- sv/rgb_to_hsv_pixel_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_top: RGB to HSV pixel converter
// Converts 8-bit RGB pixels to 16-bit hue, 8-bit saturation and 8-bit value.
// ----------------------------------------------------------------------------
// Usage:
//   Drive pixel and raise start; the request is taken at each rising edge
//   where start is high and busy is low. busy is high during reset and until
//   the first rising edge after reset is released, then stays low for good.
//   Once busy is low, a new pixel may enter on every cycle: throughput is one pixel per clock.
//   First the channels are sorted and the divisors set up, then 8 stages
//   of a pipelined restoring divider follow, each retiring two hue bits
//   and one saturation bit.
//   Each result appears on result for exactly one cycle with done high,
//   in request order. The receiver cannot stall; results are never held.
//   Reset (arst_n low) empties the pipeline at once: requests in flight are
//   dropped and no done follows for them.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_top
	import rgbhsv_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output      logic busy,
	input  wire pix_t pixel,
	output      logic done,
	output      hsv_t result
);

	logic       busy_q;
	logic       fe_vld;
	div_stage_t fe_req;

	// Hold off requests during reset and until busy_q clears after its release
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;

	rgbhsv_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start && !busy_q),
		.pixel   (pixel),
		.out_vld (fe_vld),
		.out_req (fe_req)
	);

	rgbhsv_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (fe_vld),
		.in_req  (fe_req),
		.out_vld (done),
		.out_res (result)
	);

`ifndef SYNTHESIS
	// Every result traces back to a request that was taken
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching request");

	// Black pixel gives zero saturation and zero hue
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.brightness == '0) |-> (result.saturation == '0 && result.hue == '0))
		else $error("black pixel with nonzero hue or saturation");

	// Zero saturation on a lit pixel means gray, so hue is zero
	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.saturation == '0 && result.brightness != '0) |-> result.hue == '0)
		else $error("gray pixel with nonzero hue");

	// Once released, the block never refuses a request again
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy raised after reset release");
`endif

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for the RGB to HSV pixel converter
// Sends a directed set of pixels (black, white, grays, primaries, secondaries,
// channel ties, sector edges) and then 1800 random pixels with random gaps in
// the request stream. Every result is compared field by field, in request order,
// against a typed-in expectation or a predictor of hue, saturation and value.
// ----------------------------------------------------------------------------
module tb_top;
	import rgbhsv_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RAND_PIXELS = 1800;
	localparam int CALM_TAIL   = 200;   // last random pixels sent back to back
	localparam int WDOG_LIMIT  = 500;   // cycles with no request and no result

	// Directed pixel with an optional expected result typed in
	typedef struct {
		pix_t px;
		bit   typed;
		hsv_t want;
	} dir_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	pix_t pixel  = '0;
	logic busy;
	logic done;
	hsv_t result;

	// Carried alongside each request so the accept side knows how to predict
	bit   row_typed = 1'b0;
	hsv_t row_want  = '0;

	hsv_t pending_hsv [$];
	int   err_cnt    = 0;
	int   stall_cnt  = 0;

	dir_row_t dir_rows [0:23] = '{
		'{ {8'd0,   8'd0,   8'd0},   1'b1, {16'd0,     8'd0,   8'd0}   },
		'{ {8'd255, 8'd255, 8'd255}, 1'b1, {16'd0,     8'd0,   8'd255} },
		'{ {8'd128, 8'd128, 8'd128}, 1'b1, {16'd0,     8'd0,   8'd128} },
		'{ {8'd1,   8'd1,   8'd1},   1'b1, {16'd0,     8'd0,   8'd1}   },
		'{ {8'd255, 8'd0,   8'd0},   1'b1, {16'd0,     8'd255, 8'd255} },
		'{ {8'd0,   8'd255, 8'd0},   1'b1, {16'd21845, 8'd255, 8'd255} },
		'{ {8'd0,   8'd0,   8'd255}, 1'b1, {16'd43690, 8'd255, 8'd255} },
		'{ {8'd255, 8'd255, 8'd0},   1'b1, {16'd10922, 8'd255, 8'd255} },
		'{ {8'd0,   8'd255, 8'd255}, 1'b1, {16'd32768, 8'd255, 8'd255} },
		'{ {8'd255, 8'd0,   8'd255}, 1'b1, {16'd54613, 8'd255, 8'd255} },
		'{ {8'd1,   8'd0,   8'd0},   1'b1, {16'd0,     8'd255, 8'd1}   },
		'{ {8'd0,   8'd1,   8'd0},   1'b1, {16'd21845, 8'd255, 8'd1}   },
		'{ {8'd0,   8'd0,   8'd1},   1'b1, {16'd43690, 8'd255, 8'd1}   },
		'{ {8'd255, 8'd0,   8'd1},   1'b0, '0 },
		'{ {8'd255, 8'd1,   8'd0},   1'b0, '0 },
		'{ {8'd200, 8'd10,  8'd200}, 1'b0, '0 },
		'{ {8'd10,  8'd200, 8'd200}, 1'b0, '0 },
		'{ {8'd254, 8'd255, 8'd254}, 1'b0, '0 },
		'{ {8'd170, 8'd85,  8'd0},   1'b0, '0 },
		'{ {8'd85,  8'd170, 8'd255}, 1'b0, '0 },
		'{ {8'd255, 8'd254, 8'd0},   1'b0, '0 },
		'{ {8'd1,   8'd255, 8'd0},   1'b0, '0 },
		'{ {8'd0,   8'd254, 8'd255}, 1'b0, '0 },
		'{ {8'd128, 8'd127, 8'd1},   1'b0, '0 }
	};

	rgb_to_hsv_pixel_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.pixel  (pixel),
		.done   (done),
		.result (result)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predict hue, saturation and value of one pixel
	function automatic hsv_t hsv_of(input pix_t p);
		int unsigned r, g, b, mx, mn, d, num;
		hsv_t o;
		r = p.red;
		g = p.green;
		b = p.blue;
		mx = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		o.brightness = mx[7:0];
		o.saturation = '0;
		o.hue        = '0;
		if (mx != 0)
			o.saturation = 8'((255 * d) / mx);
		if (d != 0) begin
			// red wins ties, then green; red sector wraps below a full turn
			if (mx == r)
				num = (g < b) ? 6 * d - (b - g) : g - b;
			else if (mx == g)
				num = 2 * d + b - r;
			else
				num = 4 * d + r - g;
			o.hue = 16'((num * 65536) / (6 * d));
		end
		return o;
	endfunction

	// Drive one request and hold it until taken
	task automatic send_pixel(input pix_t p, input bit typed, input hsv_t want);
		pixel     <= p;
		start     <= 1'b1;
		row_typed <= typed;
		row_want  <= want;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// Drop start and idle with junk on the pixel bus
	task automatic idle_for(input int unsigned n);
		start <= 1'b0;
		pixel <= pix_t'($urandom);
		repeat (n) @(posedge clk);
	endtask

	// Hold off new requests until every result is back
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (pending_hsv.size() != 0);
	endtask

	// Record each request taken and check each result against the oldest one
	always @(posedge clk) begin : result_check
		hsv_t want;
		if (arst_n) begin
			if (start && !busy)
				pending_hsv.push_back(row_typed ? row_want : hsv_of(pixel));
			if ($isunknown(done)) begin
				$display("%0t: done unknown, expected 0 or 1, actual %b", $time, done);
				err_cnt++;
			end else if (done) begin
				if (pending_hsv.size() == 0) begin
					$display("%0t: result with no request pending, expected none, actual %h",
						$time, result);
					err_cnt++;
				end else begin
					want = pending_hsv.pop_front();
					if (result.hue !== want.hue) begin
						$display("%0t: hue mismatch, expected %0d, actual %0d",
							$time, want.hue, result.hue);
						err_cnt++;
					end
					if (result.saturation !== want.saturation) begin
						$display("%0t: saturation mismatch, expected %0d, actual %0d",
							$time, want.saturation, result.saturation);
						err_cnt++;
					end
					if (result.brightness !== want.brightness) begin
						$display("%0t: brightness mismatch, expected %0d, actual %0d",
							$time, want.brightness, result.brightness);
						err_cnt++;
					end
				end
			end
		end
	end

	// End the run if neither side moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || done === 1'b1)
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= WDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Stimulus
	initial begin
		pix_t        rp;
		int unsigned gap_odds;
		int unsigned v;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// walk the directed table
		foreach (dir_rows[i]) begin
			send_pixel(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);
			if ($urandom_range(0, 3) == 0)
				idle_for($urandom_range(1, 11));
		end
		drain_results();

		// random pixels; gap rate changes every hundred requests
		gap_odds = 0;
		for (int n = 0; n < RAND_PIXELS; n++) begin
			if (n % 100 == 0)
				gap_odds = $urandom_range(0, 3);
			rp = pix_t'($urandom);
			v  = $urandom_range(0, 255);
			case ($urandom_range(0, 9))
				5: rp = {v[7:0], v[7:0], v[7:0]};
				6: begin
					case ($urandom_range(0, 2))
						0: rp.green = rp.red;
						1: rp.blue  = rp.red;
						default: rp.blue = rp.green;
					endcase
				end
				7: begin
					rp.red   = ($urandom_range(0, 1) != 0) ? 8'd255 - 8'($urandom_range(0, 1))
					                                       : 8'($urandom_range(0, 1));
					rp.green = ($urandom_range(0, 1) != 0) ? 8'd255 - 8'($urandom_range(0, 1))
					                                       : 8'($urandom_range(0, 1));
					rp.blue  = ($urandom_range(0, 1) != 0) ? 8'd255 - 8'($urandom_range(0, 1))
					                                       : 8'($urandom_range(0, 1));
				end
				8: rp = {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
				         8'($urandom_range(0, 3))};
				9: begin
					case ($urandom_range(0, 2))
						0: rp.red   = 8'd255;
						1: rp.green = 8'd255;
						default: rp.blue = 8'd255;
					endcase
				end
				default: ;
			endcase
			send_pixel(rp, 1'b0, '0);
			if (n == RAND_PIXELS / 2)
				drain_results();
			else if (n < RAND_PIXELS - CALM_TAIL && gap_odds != 0
			         && $urandom_range(0, gap_odds) == 0)
				idle_for($urandom_range(1, 11));
		end

		// wait out the pipeline, then give stray results a chance to show
		drain_results();
		repeat (LATENCY + 4) @(posedge clk);
		if (err_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/rgbhsv_pkg.sv
sv/rgbhsv_front.sv
sv/rgbhsv_divider.sv
sv/rgb_to_hsv_pixel_top.sv
verif/tb_top.sv
